@@ hw/rtl/ausc_pkg.sv @@
// Shared types and constants of the angle unwrap stepper command block.
package ausc_pkg;

    // One input beat: a pair of target angles, degrees with eight fraction bits.
    typedef struct packed {
        logic signed [23:0] target_angle_a;
        logic signed [23:0] target_angle_b;
    } angle_t;

    // One output beat: a stepper position command.
    typedef struct packed {
        logic        motor_select;
        logic        direction;
        logic [15:0] speed;
        logic [15:0] accel;
        logic [28:0] pulse_count;
        logic        last_of_run;
    } motor_cmd_t;

    // Configuration register indexes.
    localparam logic [1:0] REG_GLITCH_EN   = 2'd0;
    localparam logic [1:0] REG_MOTOR1_SPD  = 2'd1;
    localparam logic [1:0] REG_MOTOR1_ACC  = 2'd2;

    localparam logic [15:0] MOTOR1_SPD_RST = 16'd5000;
    localparam logic [15:0] MOTOR1_ACC_RST = 16'd256;
    localparam logic [15:0] MOTOR2_SPEED   = 16'd5000;
    localparam logic [15:0] MOTOR2_ACCEL   = 16'd0;

    localparam logic        SEL_MOTOR1     = 1'b0;
    localparam logic        SEL_MOTOR2     = 1'b1;

    // Angles in 1/256 degree.
    localparam logic signed [32:0] HALF_TURN   = 33'sd46080;
    localparam logic signed [17:0] HALF_TURN_S = 18'sd46080;
    localparam logic signed [17:0] FULL_TURN_S = 18'sd92160;
    localparam logic [16:0]        HALF_TURN_U = 17'd46080;
    localparam logic signed [32:0] GLITCH_LIM  = 33'sd2560;
    localparam logic signed [23:0] CLAMP_B     = 24'sd25600;

    localparam logic signed [31:0] SAT_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN     = 32'sh8000_0000;
    // Residues of the saturation limits modulo one full turn.
    localparam logic [16:0]        SAT_MAX_MOD = 17'd63487;
    localparam logic [16:0]        SAT_MIN_MOD = 17'd28672;

    // Whole degrees are offset by a multiple of 360 to keep them positive.
    localparam logic [16:0] DEG_OFFSET  = 17'd33120;
    localparam logic [16:0] DEG_PER_REV = 17'd360;
    // Reciprocals for exact floor division by constants.
    localparam logic [13:0] RECIP_45    = 14'd11651;     // shift 19
    localparam logic [29:0] RECIP_9     = 30'h38E38E39;  // shift 33
    localparam logic [15:0] RECIP_9_LO  = 16'd58255;     // shift 19
    localparam logic [4:0]  MUL_B       = 5'd25;

endpackage

@@ hw/rtl/angle_unwrap_stepper_command_top.sv @@
// Top level: angle unwrap with glitch reject and stepper position command generation.
//
//  channel   direction  handshake            beat
//  angle     in         angle_valid/stall    angle_t (target_angle_a, target_angle_b)
//  motor     out        motor_valid/stall    motor_cmd_t (one position command)
//  cfg       in         cfg_valid/ready      cfg_index, cfg_data (register write)
//
// A new angle pair is taken in every cycle unless angle_stall holds it; its first command
// is offered once the pair has passed through the stage registers s1 to s4.
// A pair whose clamped second angle changed yields two beats, so it holds the
// output for both beats; the unwrap stage carries the state loop.
// Reset clears the stages, the unwrap state and the registers to their defaults.
// A stall on the output backs the stages up until the input stalls in turn.
module angle_unwrap_stepper_command_top
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                angle_valid,
    output logic                angle_stall,
    input  ausc_pkg::angle_t    angle,
    output logic                motor_valid,
    input  logic                motor_stall,
    output ausc_pkg::motor_cmd_t motor_cmd,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import ausc_pkg::*;

    typedef struct packed {
        logic signed [23:0] a;
        logic [16:0]        a_mod;
        logic signed [15:0] b;
    } s2_t;

    typedef struct packed {
        logic signed [31:0] a;
        logic signed [15:0] b;
        logic               send_b;
    } s3_t;

    typedef struct packed {
        motor_cmd_t cmd1;
        motor_cmd_t cmd2;
        logic       send_b;
    } s4_t;

    // Configuration
    logic        glitch_en_reg;
    logic [15:0] m1_speed_reg;
    logic [15:0] m1_accel_reg;

    // Stage registers
    logic   s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    angle_t s1_reg;
    s2_t    s2_reg, s2_next;
    s3_t    s3_reg, s3_next;
    s4_t    s4_reg, s4_next;
    logic   phase_reg;

    // Unwrap state
    logic signed [31:0] prev_reg, prev_next;
    logic [16:0]        prev_mod_reg, prev_mod_next;
    logic signed [31:0] acc_reg, acc_next;
    logic [16:0]        acc_mod_reg, acc_mod_next;
    logic signed [15:0] prev_b_reg;

    // Flow control
    logic out_fire, out_done;
    logic load1, load2, load3, load4;
    logic free1, free2, free3, free4;

    assign out_fire = s4_valid_reg && !motor_stall;
    assign out_done = out_fire && (phase_reg || !s4_reg.send_b);
    assign free4    = !s4_valid_reg || out_done;
    assign load4    = s3_valid_reg && free4;
    assign free3    = !s3_valid_reg || load4;
    assign load3    = s2_valid_reg && free3;
    assign free2    = !s2_valid_reg || load3;
    assign load2    = s1_valid_reg && free2;
    assign free1    = !s1_valid_reg || load2;
    assign load1    = angle_valid && free1;

    assign angle_stall = !free1;
    assign cfg_ready   = 1'b1;
    assign motor_valid = s4_valid_reg;
    assign motor_cmd   = phase_reg ? s4_reg.cmd2 : s4_reg.cmd1;

    // Stage 2: residue of angle A modulo one turn, clamp of angle B.
    logic signed [15:0] a_deg;
    logic [16:0]        a_off;
    logic [27:0]        a_qprod;
    logic [8:0]         a_q;
    logic [16:0]        a_qdeg;
    logic [16:0]        a_rem;

    always_comb
    begin
        a_deg   = s1_reg.target_angle_a[23:8];
        a_off   = {a_deg[15], a_deg} + DEG_OFFSET;
        a_qprod = 28'(a_off[16:3]) * 28'(RECIP_45);
        a_q     = a_qprod[27:19];
        a_qdeg  = 17'(a_q) * DEG_PER_REV;
        a_rem   = a_off - a_qdeg;

        s2_next.a     = s1_reg.target_angle_a;
        s2_next.a_mod = {a_rem[8:0], s1_reg.target_angle_a[7:0]};
        if (s1_reg.target_angle_b > CLAMP_B)
        begin
            s2_next.b = CLAMP_B[15:0];
        end
        else if (s1_reg.target_angle_b < -CLAMP_B)
        begin
            s2_next.b = 16'(-CLAMP_B);
        end
        else
        begin
            s2_next.b = s1_reg.target_angle_b[15:0];
        end
    end

    // Stage 3: unwrap against the previous value, saturate, glitch reject.
    logic signed [32:0] delta;
    logic               in_range;
    logic signed [17:0] rdiff;
    logic [16:0]        rmod;
    logic signed [17:0] dwrap;
    logic signed [32:0] wsum;
    logic signed [31:0] a_unw;
    logic [16:0]        a_unw_mod;
    logic signed [32:0] gdiff;
    logic               glitch;

    always_comb
    begin
        delta    = 33'(s2_reg.a) - 33'(prev_reg);
        in_range = (delta >= -HALF_TURN) && (delta <= HALF_TURN);
        rdiff    = $signed({1'b0, s2_reg.a_mod}) - $signed({1'b0, prev_mod_reg});
        rmod     = (rdiff < 0) ? 17'(rdiff + FULL_TURN_S) : 17'(rdiff);

        // An exact half turn beyond the limit flips to the opposite side.
        if (rmod < HALF_TURN_U)
        begin
            dwrap = $signed({1'b0, rmod});
        end
        else if (rmod > HALF_TURN_U)
        begin
            dwrap = $signed({1'b0, rmod}) - FULL_TURN_S;
        end
        else if (delta[32])
        begin
            dwrap = HALF_TURN_S;
        end
        else
        begin
            dwrap = -HALF_TURN_S;
        end

        wsum = 33'(prev_reg) + 33'(dwrap);

        if (in_range)
        begin
            a_unw     = 32'(s2_reg.a);
            a_unw_mod = s2_reg.a_mod;
        end
        else if (wsum[32] != wsum[31])
        begin
            a_unw     = wsum[32] ? SAT_MIN : SAT_MAX;
            a_unw_mod = wsum[32] ? SAT_MIN_MOD : SAT_MAX_MOD;
        end
        else
        begin
            a_unw     = wsum[31:0];
            a_unw_mod = s2_reg.a_mod;
        end

        gdiff  = 33'(a_unw) - 33'(acc_reg);
        glitch = (acc_reg != 32'sd0) && ((gdiff > GLITCH_LIM) || (gdiff < -GLITCH_LIM));

        acc_next      = acc_reg;
        acc_mod_next  = acc_mod_reg;
        prev_next     = a_unw;
        prev_mod_next = a_unw_mod;
        if (glitch_en_reg)
        begin
            if (glitch)
            begin
                prev_next     = acc_reg;
                prev_mod_next = acc_mod_reg;
            end
            else
            begin
                acc_next     = a_unw;
                acc_mod_next = a_unw_mod;
            end
        end

        s3_next.a      = prev_next;
        s3_next.b      = s2_reg.b;
        s3_next.send_b = (s2_reg.b != prev_b_reg);
    end

    // Stage 4: pulse counts. Motor one: |a|*5/36, motor two: |b|*25/1152.
    logic [31:0] mag_a;
    logic [33:0] mag_a5;
    logic [61:0] pa_prod;
    logic [15:0] mag_b;
    logic [19:0] mag_b25;
    logic [28:0] pb_prod;

    always_comb
    begin
        mag_a   = s3_reg.a[31] ? 32'(-33'(s3_reg.a)) : 32'(s3_reg.a);
        mag_a5  = {mag_a, 2'b00} + 34'(mag_a);
        pa_prod = 62'(mag_a5[33:2]) * 62'(RECIP_9);
        mag_b   = s3_reg.b[15] ? 16'(-s3_reg.b) : 16'(s3_reg.b);
        mag_b25 = 20'(mag_b) * 20'(MUL_B);
        pb_prod = 29'(mag_b25[19:7]) * 29'(RECIP_9_LO);

        s4_next.cmd1.motor_select = SEL_MOTOR1;
        s4_next.cmd1.direction    = !s3_reg.a[31] && (s3_reg.a != 32'sd0);
        s4_next.cmd1.speed        = m1_speed_reg;
        s4_next.cmd1.accel        = m1_accel_reg;
        s4_next.cmd1.pulse_count  = pa_prod[61:33];
        s4_next.cmd1.last_of_run  = !s3_reg.send_b;

        s4_next.cmd2.motor_select = SEL_MOTOR2;
        s4_next.cmd2.direction    = s3_reg.b[15];
        s4_next.cmd2.speed        = MOTOR2_SPEED;
        s4_next.cmd2.accel        = MOTOR2_ACCEL;
        s4_next.cmd2.pulse_count  = 29'(pb_prod[28:19]);
        s4_next.cmd2.last_of_run  = 1'b1;

        s4_next.send_b = s3_reg.send_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            glitch_en_reg <= 1'b0;
            m1_speed_reg  <= MOTOR1_SPD_RST;
            m1_accel_reg  <= MOTOR1_ACC_RST;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            s4_valid_reg  <= 1'b0;
            phase_reg     <= 1'b0;
            prev_reg      <= '0;
            prev_mod_reg  <= '0;
            acc_reg       <= '0;
            acc_mod_reg   <= '0;
            prev_b_reg    <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_GLITCH_EN:  glitch_en_reg <= cfg_data[0];
                    REG_MOTOR1_SPD: m1_speed_reg  <= cfg_data;
                    REG_MOTOR1_ACC: m1_accel_reg  <= cfg_data;
                    default:        ;
                endcase
            end

            if (free1)
            begin
                s1_valid_reg <= angle_valid;
            end
            if (free2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (free3)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
            if (free4)
            begin
                s4_valid_reg <= s3_valid_reg;
            end

            // Phase selects the second command of a two-beat item.
            if (out_done)
            begin
                phase_reg <= 1'b0;
            end
            else if (out_fire)
            begin
                phase_reg <= 1'b1;
            end

            if (load3)
            begin
                prev_reg     <= prev_next;
                prev_mod_reg <= prev_mod_next;
                acc_reg      <= acc_next;
                acc_mod_reg  <= acc_mod_next;
                if (s3_next.send_b)
                begin
                    prev_b_reg <= s2_reg.b;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load1)
        begin
            s1_reg <= angle;
        end
        if (load2)
        begin
            s2_reg <= s2_next;
        end
        if (load3)
        begin
            s3_reg <= s3_next;
        end
        if (load4)
        begin
            s4_reg <= s4_next;
        end
    end

endmodule
